// File: src/dpt_pkg.sv
// shared types and constants for the device parent table
package dpt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 16;
    localparam int CID_W     = 15;
    localparam int CNT_W     = 5;
    localparam int MAXC_W    = 5;

    localparam logic signed [ID_W-1:0] NO_PARENT = -16'sd1;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_GET     = 2'd2,
        OP_COLLECT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK          = 2'd0,
        STS_INVALID     = 2'd1,
        STS_NOT_ALLOWED = 2'd2,
        STS_NOT_FOUND   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_ORPHAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        status_t status;
        logic    with_parent;
        logic    with_count;
    } fin_t;

    typedef struct packed {
        logic load;
        logic scan_en;
        logic scan_restart;
        logic orphan;
        logic commit_add;
        logic commit_remove;
        logic emit_final;
        fin_t fin;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic id_neg;
        logic maxc_zero;
        logic scan_done;
        logic found;
        logic dup;
        logic overflow;
        logic out_free;
    } stat_t;

endpackage

// File: src/dpt_ctrl.sv
// operation sequencer for the device parent table
module dpt_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  dpt_pkg::stat_t  st,
    output dpt_pkg::cmd_t   cmd
);

    dpt_pkg::state_t state_reg;
    dpt_pkg::state_t state_next;
    dpt_pkg::fin_t   fin_reg;
    dpt_pkg::fin_t   fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dpt_pkg::S_IDLE;
            fin_reg   <= '{dpt_pkg::STS_OK, 1'b0, 1'b0};
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        cmd.fin    = fin_reg;
        in_stall   = (state_reg != dpt_pkg::S_IDLE);
        case (state_reg)
            dpt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dpt_pkg::S_START;
                end
            end
            dpt_pkg::S_START:
            begin
                if ((st.op == dpt_pkg::OP_ADD && st.id_neg) ||
                    (st.op == dpt_pkg::OP_COLLECT && st.maxc_zero))
                begin
                    fin_next   = '{dpt_pkg::STS_INVALID, 1'b0, 1'b0};
                    state_next = dpt_pkg::S_FINISH;
                end
                else
                begin
                    state_next = dpt_pkg::S_SCAN;
                end
            end
            dpt_pkg::S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (st.overflow)
                begin
                    fin_next   = '{dpt_pkg::STS_NOT_ALLOWED, 1'b0, 1'b0};
                    state_next = dpt_pkg::S_FINISH;
                end
                else if (st.scan_done)
                begin
                    state_next = dpt_pkg::S_FINISH;
                    case (st.op)
                        dpt_pkg::OP_ADD:
                        begin
                            if (!st.dup && st.found)
                            begin
                                cmd.commit_add = 1'b1;
                                fin_next = '{dpt_pkg::STS_OK, 1'b0, 1'b0};
                            end
                            else
                            begin
                                fin_next = '{dpt_pkg::STS_NOT_ALLOWED, 1'b0, 1'b0};
                            end
                        end
                        dpt_pkg::OP_REMOVE:
                        begin
                            if (st.found)
                            begin
                                cmd.commit_remove = 1'b1;
                                cmd.scan_restart  = 1'b1;
                                state_next        = dpt_pkg::S_ORPHAN;
                            end
                            else
                            begin
                                fin_next = '{dpt_pkg::STS_NOT_FOUND, 1'b0, 1'b0};
                            end
                        end
                        dpt_pkg::OP_GET:
                        begin
                            if (st.found)
                                fin_next = '{dpt_pkg::STS_OK, 1'b1, 1'b0};
                            else
                                fin_next = '{dpt_pkg::STS_NOT_FOUND, 1'b0, 1'b0};
                        end
                        default:
                        begin
                            fin_next = '{dpt_pkg::STS_OK, 1'b0, 1'b1};
                        end
                    endcase
                end
            end
            dpt_pkg::S_ORPHAN:
            begin
                cmd.scan_en = 1'b1;
                cmd.orphan  = 1'b1;
                if (st.scan_done)
                begin
                    fin_next   = '{dpt_pkg::STS_OK, 1'b0, 1'b0};
                    state_next = dpt_pkg::S_FINISH;
                end
            end
            dpt_pkg::S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = dpt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dpt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: src/dpt_dp.sv
// table storage, slot scan and result register for the device parent table
module dpt_dp
#(
    parameter int TABLE_DEPTH = dpt_pkg::DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [dpt_pkg::CID_W-1:0]           cfg_wr_data,
    input  logic [1:0]                          op,
    input  logic signed [dpt_pkg::ID_W-1:0]     id,
    input  logic [dpt_pkg::MAXC_W-1:0]          child_limit,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic signed [dpt_pkg::ID_W-1:0]     parent_dev,
    output logic [dpt_pkg::CID_W-1:0]           child_id,
    output logic                                child_valid,
    output logic [dpt_pkg::CNT_W-1:0]           child_count,
    output logic                                last,
    input  dpt_pkg::cmd_t                       cmd,
    output dpt_pkg::stat_t                      st
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // table
    logic [TABLE_DEPTH-1:0]             entry_valid_reg;
    logic [dpt_pkg::CID_W-1:0]          mem_id [TABLE_DEPTH];
    logic signed [dpt_pkg::ID_W-1:0]    mem_par [TABLE_DEPTH];
    logic [dpt_pkg::CID_W-1:0]          ctrl_id_reg;

    // captured request
    dpt_pkg::op_t                       q_op_reg;
    logic signed [dpt_pkg::ID_W-1:0]    q_id_reg;
    logic [dpt_pkg::MAXC_W-1:0]         q_maxc_reg;

    // scan pipeline
    logic [CW-1:0]                      iss_cnt_reg;
    logic                               chk_vld_reg;
    logic [IW-1:0]                      chk_idx_reg;
    logic [dpt_pkg::CID_W-1:0]          rd_id_reg;
    logic signed [dpt_pkg::ID_W-1:0]    rd_par_reg;
    logic                               found_reg;
    logic                               dup_reg;
    logic [IW-1:0]                      slot_reg;
    logic signed [dpt_pkg::ID_W-1:0]    par_cap_reg;
    logic [dpt_pkg::CNT_W-1:0]          n_reg;

    // result register
    logic                               out_valid_reg;
    dpt_pkg::status_t                   out_status_reg;
    logic signed [dpt_pkg::ID_W-1:0]    out_parent_reg;
    logic [dpt_pkg::CID_W-1:0]          out_child_reg;
    logic                               out_cv_reg;
    logic [dpt_pkg::CNT_W-1:0]          out_count_reg;
    logic                               out_last_reg;

    logic out_free;
    logic adv;
    logic issue;
    logic ev;
    logic id_hit;
    logic par_hit;
    logic over_lim;
    logic ld_child;
    logic orphan_wr;

    assign out_free  = !out_valid_reg || !out_stall;
    assign adv       = cmd.scan_en && out_free;
    assign issue     = adv && (iss_cnt_reg < CW'(TABLE_DEPTH));
    assign ev        = entry_valid_reg[chk_idx_reg];
    assign id_hit    = ev && !q_id_reg[dpt_pkg::ID_W-1]
                       && (rd_id_reg == q_id_reg[dpt_pkg::CID_W-1:0]);
    assign par_hit   = ev && (rd_par_reg == q_id_reg);
    assign over_lim  = (n_reg >= q_maxc_reg);
    assign ld_child  = adv && chk_vld_reg && !cmd.orphan
                       && (q_op_reg == dpt_pkg::OP_COLLECT) && par_hit && !over_lim;
    assign orphan_wr = adv && chk_vld_reg && cmd.orphan && par_hit;

    assign st.op        = q_op_reg;
    assign st.id_neg    = q_id_reg[dpt_pkg::ID_W-1];
    assign st.maxc_zero = (q_maxc_reg == '0);
    assign st.scan_done = (iss_cnt_reg == CW'(TABLE_DEPTH)) && !chk_vld_reg;
    assign st.found     = found_reg;
    assign st.dup       = dup_reg;
    assign st.overflow  = chk_vld_reg && !cmd.orphan
                          && (q_op_reg == dpt_pkg::OP_COLLECT) && par_hit && over_lim;
    assign st.out_free  = out_free;

    // config and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_id_reg     <= '0;
            entry_valid_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                ctrl_id_reg <= cfg_wr_data;
            if (cmd.commit_add)
                entry_valid_reg[slot_reg] <= 1'b1;
            if (cmd.commit_remove)
                entry_valid_reg[slot_reg] <= 1'b0;
        end
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (cmd.commit_add)
        begin
            mem_id[slot_reg]  <= q_id_reg[dpt_pkg::CID_W-1:0];
            mem_par[slot_reg] <= {1'b0, ctrl_id_reg};
        end
        else if (orphan_wr)
        begin
            mem_par[chk_idx_reg] <= dpt_pkg::NO_PARENT;
        end
        if (issue)
        begin
            rd_id_reg  <= mem_id[iss_cnt_reg[IW-1:0]];
            rd_par_reg <= mem_par[iss_cnt_reg[IW-1:0]];
        end
    end

    // scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_cnt_reg <= '0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            dup_reg     <= 1'b0;
            n_reg       <= '0;
        end
        else if (cmd.load)
        begin
            iss_cnt_reg <= '0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            dup_reg     <= 1'b0;
            n_reg       <= '0;
        end
        else if (cmd.scan_restart)
        begin
            iss_cnt_reg <= '0;
            chk_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            chk_vld_reg <= issue;
            if (issue)
                iss_cnt_reg <= iss_cnt_reg + CW'(1);
            if (chk_vld_reg && !cmd.orphan)
            begin
                if (q_op_reg == dpt_pkg::OP_ADD)
                begin
                    if (id_hit)
                        dup_reg <= 1'b1;
                    if (!ev && !found_reg)
                        found_reg <= 1'b1;
                end
                else if (id_hit && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (ld_child)
                n_reg <= n_reg + dpt_pkg::CNT_W'(1);
        end
    end

    // scan payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_op_reg   <= dpt_pkg::op_t'(op);
            q_id_reg   <= id;
            q_maxc_reg <= child_limit;
        end
        if (issue)
            chk_idx_reg <= iss_cnt_reg[IW-1:0];
        if (adv && chk_vld_reg && !cmd.orphan && !found_reg)
        begin
            if ((q_op_reg == dpt_pkg::OP_ADD) ? !ev : id_hit)
            begin
                slot_reg    <= chk_idx_reg;
                par_cap_reg <= rd_par_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ld_child || cmd.emit_final)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ld_child)
        begin
            out_status_reg <= dpt_pkg::STS_OK;
            out_parent_reg <= '0;
            out_child_reg  <= rd_id_reg;
            out_cv_reg     <= 1'b1;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.emit_final)
        begin
            out_status_reg <= cmd.fin.status;
            out_parent_reg <= cmd.fin.with_parent ? par_cap_reg : '0;
            out_child_reg  <= '0;
            out_cv_reg     <= 1'b0;
            out_count_reg  <= cmd.fin.with_count ? n_reg : '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign parent_dev  = out_parent_reg;
    assign child_id    = out_child_reg;
    assign child_valid = out_cv_reg;
    assign child_count = out_count_reg;
    assign last        = out_last_reg;

endmodule

// File: src/device_parent_table_top.sv
// top level of the device parent table
//
// requests come in on in_valid/in_stall with op, id and child_limit; a
// request transfers when in_valid is high and in_stall is low. results go
// out on out_valid/out_stall, one transfer per result, the final one with
// last set. add, remove and get parent give one result; collect gives one
// result per matching child in slot order, then a final status result.
// the user must write the controller id register through cfg_wr_en/cfg_wr_data
// only while idle; the block itself does not enforce this. every operation but
// an early error walks the table one slot per cycle, while no result-side stall
// holds it, through the single read port of the table memory, whose read is
// registered. remove does a lookup walk then an orphaning walk; an add with a
// negative id or a collect with a zero limit is an early error and ends
// without a walk. in_stall is high from the request transfer until the final
// result is placed, so a new request is not taken before the last one is
// through; the next request can transfer in the cycle after the final result
// is placed. a stall on the result side freezes the walk until the result
// moves. reset clears all valid flags at once and sets the controller id to 0.
module device_parent_table_top
#(
    parameter int TABLE_DEPTH = dpt_pkg::DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [dpt_pkg::CID_W-1:0]           cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          op,
    input  logic signed [dpt_pkg::ID_W-1:0]     id,
    input  logic [dpt_pkg::MAXC_W-1:0]          child_limit,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic signed [dpt_pkg::ID_W-1:0]     parent_dev,
    output logic [dpt_pkg::CID_W-1:0]           child_id,
    output logic                                child_valid,
    output logic [dpt_pkg::CNT_W-1:0]           child_count,
    output logic                                last
);

    dpt_pkg::cmd_t  cmd;
    dpt_pkg::stat_t st;

    dpt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    dpt_dp
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .op           (op),
        .id           (id),
        .child_limit  (child_limit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .parent_dev   (parent_dev),
        .child_id     (child_id),
        .child_valid  (child_valid),
        .child_count  (child_count),
        .last         (last),
        .cmd          (cmd),
        .st           (st)
    );

endmodule

// File: src/dpt_chk.sv
// port checker for the device parent table
module dpt_chk
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [1:0]                          status,
    input  logic signed [dpt_pkg::ID_W-1:0]     parent_dev,
    input  logic [dpt_pkg::CID_W-1:0]           child_id,
    input  logic                                child_valid,
    input  logic [dpt_pkg::CNT_W-1:0]           child_count,
    input  logic                                last
);

    // held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // child results are never final and always ok
    a_child_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && child_valid |-> !last && status == dpt_pkg::STS_OK
        && child_count == '0 && parent_dev == '0)
        else $error("malformed child result");

    // failed final results carry no count and no parent
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != dpt_pkg::STS_OK |-> last && child_count == '0
        && parent_dev == '0 && !child_valid)
        else $error("error result carries data");

    // a non-child result is always final
    a_nonchild_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !child_valid |-> last && child_id == '0)
        else $error("non-child result not final");

endmodule

bind device_parent_table_top dpt_chk u_dpt_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .parent_dev  (parent_dev),
    .child_id    (child_id),
    .child_valid (child_valid),
    .child_count (child_count),
    .last        (last)
);
